// File: rtl/clps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clps_pkg
// Shared types, codes and command helpers for the character LCD sequencer.
// ----------------------------------------------------------------------------
package clps_pkg;

   localparam int MAX_STRING_DEF = 32;
   localparam int QUEUE_DEPTH    = 2;
   localparam int CSR_INDEX_W    = 3;

   localparam logic [7:0] LINE1_BASE = 8'h80;
   localparam logic [7:0] LINE2_BASE = 8'hC0;
   localparam logic [7:0] CLEAR_CMD  = 8'b0000_0001;

   localparam logic [CSR_INDEX_W-1:0] CSR_TWO_LINES      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FONT_LARGE     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_ON     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURSOR_ON      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLINK_ON       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_INCREMENT_MODE = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_SHIFT  = 3'd6;

   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;
   localparam logic [1:0] KIND_MOVE  = 2'd3;

   localparam logic [1:0] INIT_LAST_STEP = 2'd3;

   typedef enum logic [1:0] {
      STATUS_ACCEPTED = 2'd0,
      STATUS_REFUSED  = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      DONE_NONE  = 2'd0,
      DONE_WRITE = 2'd1,
      DONE_CLEAR = 2'd2,
      DONE_MOVE  = 2'd3
   } done_type;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_CLEAR = 2'd2,
      OP_MOVE  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      MODE_IDLE  = 4'b0001,
      MODE_WRITE = 4'b0010,
      MODE_CLEAR = 4'b0100,
      MODE_MOVE  = 4'b1000
   } mode_type;

   typedef struct packed {
      logic two_lines;
      logic font_large;
      logic display_on;
      logic cursor_on;
      logic blink_on;
      logic increment_mode;
      logic display_shift;
   } cfg_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] char_code;
      logic       last_char;
      logic       row_known;
      logic [7:0] move_cmd;
   } item_type;

   function automatic logic [7:0] init_command(input logic [1:0] step, input cfg_type cfg);
      logic [7:0] cmd;
      case (step)
         2'd0: cmd = 8'h30 | {4'b0, cfg.two_lines, cfg.font_large, 2'b0};
         2'd1: cmd = 8'h08 | {5'b0, cfg.display_on, cfg.cursor_on, cfg.blink_on};
         2'd2: cmd = CLEAR_CMD;
         default: cmd = 8'h04 | {6'b0, cfg.increment_mode, cfg.display_shift};
      endcase
      return cmd;
   endfunction

endpackage
`default_nettype wire

// File: rtl/clps_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clps_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
module clps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/clps_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clps_front
// Input stage: takes request items, decodes kind and precomputes the move
// command byte, then hands the item to the queue.
// ----------------------------------------------------------------------------
module clps_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [1:0]        req_kind,
   input  wire logic [7:0]        req_char_code,
   input  wire logic              req_last_char,
   input  wire logic [1:0]        req_row,
   input  wire logic [5:0]        req_column,
   output logic                   push_valid,
   output clps_pkg::item_type     push_item,
   input  wire logic              queue_full
);

   logic                 valid_ff, valid_in;
   clps_pkg::item_type   item_ff, item_in;
   logic                 accept;
   logic                 pushed;
   logic [7:0]           base;

   assign pushed    = valid_ff && !queue_full;
   assign req_stall = valid_ff && queue_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      case (req_kind)
         clps_pkg::KIND_TICK:  item_in.op = clps_pkg::OP_TICK;
         clps_pkg::KIND_WRITE: item_in.op = clps_pkg::OP_WRITE;
         clps_pkg::KIND_CLEAR: item_in.op = clps_pkg::OP_CLEAR;
         default:              item_in.op = clps_pkg::OP_MOVE;
      endcase
      base = (req_row == 2'd1) ? clps_pkg::LINE2_BASE : clps_pkg::LINE1_BASE;
      item_in.char_code = req_char_code;
      item_in.last_char = req_last_char;
      item_in.row_known = (req_row == 2'd0) || (req_row == 2'd1);
      item_in.move_cmd  = base + {2'b0, req_column};
   end

   assign valid_in = accept || (valid_ff && !pushed);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign push_valid = pushed;
   assign push_item  = item_ff;

endmodule
`default_nettype wire

// File: rtl/clps_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clps_queue
// Short FIFO of decoded items between the front and back stages.
// ----------------------------------------------------------------------------
module clps_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire clps_pkg::item_type push_item,
   output logic                   full,
   input  wire logic              pop,
   output logic                   head_valid,
   output clps_pkg::item_type     head_item
);

   localparam int DEPTH = clps_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   clps_pkg::item_type entry_ff [DEPTH];
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]      count_ff, count_in;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] ptr);
      logic [PW-1:0] nxt;
      if (ptr == PW'(DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + PW'(1);
      end
      return nxt;
   endfunction

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// File: rtl/clps_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clps_back
// Execution stage: bus sequencing, string buffer and result register.
// ----------------------------------------------------------------------------
module clps_back #(
   parameter int MAX_STRING = clps_pkg::MAX_STRING_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire clps_pkg::cfg_type cfg,
   input  wire logic              head_valid,
   input  wire clps_pkg::item_type head_item,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [1:0]             rsp_status,
   output logic                   rsp_reg_select,
   output logic                   rsp_read_write,
   output logic                   rsp_enable_pin,
   output logic [7:0]             rsp_data_bus,
   output logic [1:0]             rsp_done_kind
);

   localparam int LW = $clog2(MAX_STRING + 1);
   localparam int AW = (MAX_STRING > 1) ? $clog2(MAX_STRING) : 1;

   clps_pkg::mode_type   mode_ff, mode_in;
   logic [1:0]           step_ff, step_in;
   logic                 init_done_ff, init_done_in;
   logic                 e_ff, e_in;
   logic                 rs_ff, rs_in;
   logic [7:0]           data_ff, data_in;
   logic [LW-1:0]        idx_ff, idx_in;
   logic [LW-1:0]        len_ff, len_in;
   logic                 row_known_ff, row_known_in;
   logic [7:0]           move_cmd_ff, move_cmd_in;
   logic                 fresh_ff, fresh_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   clps_pkg::status_type st_ff, st_in;
   clps_pkg::done_type   done_ff, done_in;
   logic                 out_rs_ff, out_e_ff;
   logic [7:0]           out_data_ff;

   logic                 out_ready;
   logic                 need_data;
   logic                 proc;
   logic                 ram_we;
   logic [7:0]           ram_rd_data;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign need_data = (head_item.op == clps_pkg::OP_TICK) && init_done_ff
                      && (mode_ff == clps_pkg::MODE_WRITE) && !e_ff
                      && (idx_ff < len_ff);
   assign proc      = head_valid && out_ready && !(need_data && !fresh_ff);
   assign pop       = proc;

   clps_ram #(
      .WIDTH(8),
      .DEPTH(MAX_STRING)
   ) u_buffer (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(len_ff[AW-1:0]),
      .wr_data(head_item.char_code),
      .rd_addr(idx_ff[AW-1:0]),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      mode_in      = mode_ff;
      step_in      = step_ff;
      init_done_in = init_done_ff;
      e_in         = e_ff;
      rs_in        = rs_ff;
      data_in      = data_ff;
      idx_in       = idx_ff;
      len_in       = len_ff;
      row_known_in = row_known_ff;
      move_cmd_in  = move_cmd_ff;
      st_in        = clps_pkg::STATUS_ACCEPTED;
      done_in      = clps_pkg::DONE_NONE;
      ram_we       = 1'b0;
      if (proc) begin
         case (head_item.op)
            clps_pkg::OP_TICK: begin
               if (!init_done_ff) begin
                  if (e_ff) begin
                     e_in = 1'b0;
                     if (step_ff == clps_pkg::INIT_LAST_STEP) begin
                        init_done_in = 1'b1;
                     end else begin
                        step_in = step_ff + 2'd1;
                     end
                  end else begin
                     data_in = clps_pkg::init_command(step_ff, cfg);
                     rs_in   = 1'b0;
                     e_in    = 1'b1;
                  end
               end else begin
                  case (mode_ff)
                     clps_pkg::MODE_WRITE: begin
                        if (e_ff) begin
                           e_in = 1'b0;
                        end else if (idx_ff >= len_ff) begin
                           idx_in  = '0;
                           len_in  = '0;
                           mode_in = clps_pkg::MODE_IDLE;
                           done_in = clps_pkg::DONE_WRITE;
                        end else begin
                           data_in = ram_rd_data;
                           rs_in   = 1'b1;
                           e_in    = 1'b1;
                           idx_in  = idx_ff + LW'(1);
                        end
                     end
                     clps_pkg::MODE_CLEAR: begin
                        if (e_ff) begin
                           e_in    = 1'b0;
                           mode_in = clps_pkg::MODE_IDLE;
                           done_in = clps_pkg::DONE_CLEAR;
                        end else begin
                           data_in = clps_pkg::CLEAR_CMD;
                           rs_in   = 1'b0;
                           e_in    = 1'b1;
                        end
                     end
                     clps_pkg::MODE_MOVE: begin
                        if (e_ff) begin
                           e_in    = 1'b0;
                           mode_in = clps_pkg::MODE_IDLE;
                           done_in = clps_pkg::DONE_MOVE;
                        end else if (row_known_ff) begin
                           data_in = move_cmd_ff;
                           rs_in   = 1'b0;
                           e_in    = 1'b1;
                        end else begin
                           e_in = 1'b1;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            default: begin
               if (mode_ff != clps_pkg::MODE_IDLE) begin
                  st_in = clps_pkg::STATUS_REFUSED;
               end else begin
                  case (head_item.op)
                     clps_pkg::OP_WRITE: begin
                        if (len_ff < LW'(MAX_STRING)) begin
                           ram_we = 1'b1;
                           len_in = len_ff + LW'(1);
                        end else begin
                           st_in = clps_pkg::STATUS_OVERFLOW;
                        end
                        if (head_item.last_char) begin
                           mode_in = clps_pkg::MODE_WRITE;
                           idx_in  = '0;
                        end
                     end
                     clps_pkg::OP_CLEAR: begin
                        mode_in = clps_pkg::MODE_CLEAR;
                     end
                     default: begin
                        row_known_in = head_item.row_known;
                        move_cmd_in  = head_item.move_cmd;
                        mode_in      = clps_pkg::MODE_MOVE;
                     end
                  endcase
               end
            end
         endcase
      end
      fresh_in     = (idx_in == idx_ff) && !ram_we;
      rsp_valid_in = proc || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= clps_pkg::MODE_IDLE;
         step_ff      <= '0;
         init_done_ff <= 1'b0;
         e_ff         <= 1'b0;
         rs_ff        <= 1'b0;
         data_ff      <= '0;
         idx_ff       <= '0;
         len_ff       <= '0;
         row_known_ff <= 1'b1;
         move_cmd_ff  <= clps_pkg::LINE1_BASE;
         fresh_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         step_ff      <= step_in;
         init_done_ff <= init_done_in;
         e_ff         <= e_in;
         rs_ff        <= rs_in;
         data_ff      <= data_in;
         idx_ff       <= idx_in;
         len_ff       <= len_in;
         row_known_ff <= row_known_in;
         move_cmd_ff  <= move_cmd_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (proc) begin
         st_ff       <= st_in;
         done_ff     <= done_in;
         out_rs_ff   <= rs_in;
         out_e_ff    <= e_in;
         out_data_ff <= data_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = st_ff;
   assign rsp_reg_select = out_rs_ff;
   assign rsp_read_write = 1'b0;
   assign rsp_enable_pin = out_e_ff;
   assign rsp_data_bus   = out_data_ff;
   assign rsp_done_kind  = done_ff;

endmodule
`default_nettype wire

// File: rtl/char_lcd_parallel_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_parallel_sequencer
// 8-bit character LCD bus sequencer: init sequence, string writes, clear
// and cursor moves, one bus step per tick item.
// ----------------------------------------------------------------------------
// One item per clock sustained while the result side does not stall. An item
// passes an input register, a two-entry queue and the execution stage into
// the result register. The string buffer has a registered read port: the
// first data tick right after a write is armed waits for the buffer read.
// The buffer is not cleared after reset; only bytes written for the current
// string are ever read. Configuration writes are always ready and are
// registered before they take effect.
// ----------------------------------------------------------------------------
module char_lcd_parallel_sequencer #(
   parameter int MAX_STRING = clps_pkg::MAX_STRING_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [1:0]                       req_kind,
   input  wire logic [7:0]                       req_char_code,
   input  wire logic                             req_last_char,
   input  wire logic [1:0]                       req_row,
   input  wire logic [5:0]                       req_column,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [1:0]                            rsp_status,
   output logic                                  rsp_reg_select,
   output logic                                  rsp_read_write,
   output logic                                  rsp_enable_pin,
   output logic [7:0]                            rsp_data_bus,
   output logic [1:0]                            rsp_done_kind,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [clps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic                             csr_wdata
);

   clps_pkg::cfg_type  cfg_ff, cfg_in;
   logic               push_valid;
   clps_pkg::item_type push_item;
   logic               queue_full;
   logic               pop;
   logic               head_valid;
   clps_pkg::item_type head_item;
   logic               csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            clps_pkg::CSR_TWO_LINES:      cfg_in.two_lines      = csr_wdata;
            clps_pkg::CSR_FONT_LARGE:     cfg_in.font_large     = csr_wdata;
            clps_pkg::CSR_DISPLAY_ON:     cfg_in.display_on     = csr_wdata;
            clps_pkg::CSR_CURSOR_ON:      cfg_in.cursor_on      = csr_wdata;
            clps_pkg::CSR_BLINK_ON:       cfg_in.blink_on       = csr_wdata;
            clps_pkg::CSR_INCREMENT_MODE: cfg_in.increment_mode = csr_wdata;
            clps_pkg::CSR_DISPLAY_SHIFT:  cfg_in.display_shift  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.two_lines      <= 1'b1;
         cfg_ff.font_large     <= 1'b0;
         cfg_ff.display_on     <= 1'b1;
         cfg_ff.cursor_on      <= 1'b0;
         cfg_ff.blink_on       <= 1'b0;
         cfg_ff.increment_mode <= 1'b1;
         cfg_ff.display_shift  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   clps_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_kind     (req_kind),
      .req_char_code(req_char_code),
      .req_last_char(req_last_char),
      .req_row      (req_row),
      .req_column   (req_column),
      .push_valid   (push_valid),
      .push_item    (push_item),
      .queue_full   (queue_full)
   );

   clps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .head_valid(head_valid),
      .head_item (head_item)
   );

   clps_back #(
      .MAX_STRING(MAX_STRING)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_reg_select(rsp_reg_select),
      .rsp_read_write(rsp_read_write),
      .rsp_enable_pin(rsp_enable_pin),
      .rsp_data_bus  (rsp_data_bus),
      .rsp_done_kind (rsp_done_kind)
   );

endmodule
`default_nettype wire

// File: tb/char_lcd_parallel_sequencer_tb.sv
// ----------------------------------------------------------------------------
// char_lcd_parallel_sequencer_tb
// Self-checking bench for the character LCD bus sequencer. A behavioral
// model of the bus state is updated on every accepted item, and the
// expected pin levels, status and completion code of each item are checked
// in order against the result channel. Covers the power-on command
// sequence under changing options, string writes, clear and cursor moves,
// refused requests, buffer overflow and random traffic, with random gaps
// on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module char_lcd_parallel_sequencer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import clps_pkg::*;

   localparam int TOTAL_ITEMS   = 1450;
   localparam int PHASE_ITEMS   = 150;
   localparam int SETTLE_CYCLES = 6;
   localparam int IDLE_LIMIT    = 5000;
   localparam int REPORT_LIMIT  = 40;

   localparam cfg_type POWER_ON_OPTIONS = '{two_lines: 1'b1, font_large: 1'b0,
      display_on: 1'b1, cursor_on: 1'b0, blink_on: 1'b0, increment_mode: 1'b1,
      display_shift: 1'b0};

   typedef struct {
      status_type status;
      logic       rs;
      logic       rw;
      logic       e;
      logic [7:0] data;
      done_type   done;
   } bus_state_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [1:0]             req_kind;
   logic [7:0]             req_char_code;
   logic                   req_last_char;
   logic [1:0]             req_row;
   logic [5:0]             req_column;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [1:0]             rsp_status;
   logic                   rsp_reg_select;
   logic                   rsp_read_write;
   logic                   rsp_enable_pin;
   logic [7:0]             rsp_data_bus;
   logic [1:0]             rsp_done_kind;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic                   csr_wdata;

   // bus model state
   cfg_type    lcd_cfg;
   mode_type   lcd_mode;
   logic [1:0] setup_step;
   logic       setup_done;
   logic       e_raised;
   int         send_index;
   int         text_length;
   logic [7:0] text_buf [MAX_STRING_DEF];
   logic [1:0] move_row;
   logic [5:0] move_col;
   logic       pin_rs;
   logic       pin_e;
   logic [7:0] pin_data;

   bus_state_type pending_pin_states [$];
   int            handled_items;
   int            result_count;
   int            mismatch_count;
   int            idle_cycles;
   bit            req_quiet;
   bit            rsp_quiet;

   char_lcd_parallel_sequencer u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_char_code  (req_char_code),
      .req_last_char  (req_last_char),
      .req_row        (req_row),
      .req_column     (req_column),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_reg_select (rsp_reg_select),
      .rsp_read_write (rsp_read_write),
      .rsp_enable_pin (rsp_enable_pin),
      .rsp_data_bus   (rsp_data_bus),
      .rsp_done_kind  (rsp_done_kind),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void reset_bus_model();
      lcd_cfg     = POWER_ON_OPTIONS;
      lcd_mode    = MODE_IDLE;
      setup_step  = '0;
      setup_done  = 1'b0;
      e_raised    = 1'b0;
      send_index  = 0;
      text_length = 0;
      move_row    = '0;
      move_col    = '0;
      pin_rs      = 1'b0;
      pin_e       = 1'b0;
      pin_data    = '0;
      foreach (text_buf[i]) text_buf[i] = '0;
   endfunction

   function automatic void drive_bus(logic [7:0] value, logic is_data);
      pin_data = value;
      pin_rs   = is_data;
      pin_e    = 1'b1;
      e_raised = 1'b1;
   endfunction

   function automatic void release_enable();
      pin_e    = 1'b0;
      e_raised = 1'b0;
   endfunction

   function automatic logic [7:0] setup_command(logic [1:0] step);
      case (step)
         2'd0: return {4'b0011, lcd_cfg.two_lines, lcd_cfg.font_large, 2'b00};
         2'd1: return {5'b00001, lcd_cfg.display_on, lcd_cfg.cursor_on, lcd_cfg.blink_on};
         2'd2: return CLEAR_CMD;
         default: return {6'b000001, lcd_cfg.increment_mode, lcd_cfg.display_shift};
      endcase
   endfunction

   function automatic done_type advance_bus();
      done_type done;
      done = DONE_NONE;
      if (!setup_done) begin
         if (e_raised) begin
            release_enable();
            if (setup_step == INIT_LAST_STEP) setup_done = 1'b1;
            else setup_step = setup_step + 2'd1;
         end else begin
            drive_bus(setup_command(setup_step), 1'b0);
         end
         return done;
      end
      case (lcd_mode)
         MODE_WRITE: begin
            if (e_raised) begin
               release_enable();
            end else if (send_index >= text_length) begin
               send_index  = 0;
               text_length = 0;
               lcd_mode    = MODE_IDLE;
               done        = DONE_WRITE;
            end else begin
               drive_bus(text_buf[send_index], 1'b1);
               send_index++;
            end
         end
         MODE_CLEAR: begin
            if (e_raised) begin
               release_enable();
               lcd_mode = MODE_IDLE;
               done     = DONE_CLEAR;
            end else begin
               drive_bus(CLEAR_CMD, 1'b0);
            end
         end
         MODE_MOVE: begin
            if (e_raised) begin
               release_enable();
               lcd_mode = MODE_IDLE;
               done     = DONE_MOVE;
            end else if (move_row == 2'd0) begin
               drive_bus(8'(LINE1_BASE + {2'b00, move_col}), 1'b0);
            end else if (move_row == 2'd1) begin
               drive_bus(8'(LINE2_BASE + {2'b00, move_col}), 1'b0);
            end else begin
               // unknown row: strobe only
               pin_e    = 1'b1;
               e_raised = 1'b1;
            end
         end
         default: ;
      endcase
      return done;
   endfunction

   function automatic void predict_bus_state(op_type kind, logic [7:0] code, logic last,
                                             logic [1:0] row, logic [5:0] col);
      bus_state_type st;
      st.status = STATUS_ACCEPTED;
      st.done   = DONE_NONE;
      if (kind == OP_TICK) begin
         st.done = advance_bus();
      end else if (lcd_mode != MODE_IDLE) begin
         st.status = STATUS_REFUSED;
      end else if (kind == OP_WRITE) begin
         if (text_length < MAX_STRING_DEF) begin
            text_buf[text_length] = code;
            text_length++;
         end else begin
            st.status = STATUS_OVERFLOW;
         end
         if (last) begin
            lcd_mode   = MODE_WRITE;
            send_index = 0;
         end
      end else if (kind == OP_CLEAR) begin
         lcd_mode = MODE_CLEAR;
      end else begin
         move_row = row;
         move_col = col;
         lcd_mode = MODE_MOVE;
      end
      st.rs   = pin_rs;
      st.rw   = 1'b0;
      st.e    = pin_e;
      st.data = pin_data;
      pending_pin_states.push_back(st);
      handled_items++;
   endfunction

   function automatic int pick_gap(bit quiet);
      int roll;
      if (quiet) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
                  $time, result_count, what, got, want);
   endtask

   task automatic send_item(op_type kind, logic [7:0] code, logic last,
                            logic [1:0] row, logic [5:0] col);
      int gap;
      gap = pick_gap(req_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_char_code <= code;
      req_last_char <= last;
      req_row       <= row;
      req_column    <= col;
      do @(posedge clock); while (req_stall);
      predict_bus_state(kind, code, last, row, col);
   endtask

   task automatic send_tick();
      send_item(OP_TICK, 8'($urandom), 1'($urandom), 2'($urandom), 6'($urandom));
   endtask

   task automatic send_request(op_type kind);
      send_item(kind, 8'($urandom), 1'($urandom), 2'($urandom), 6'($urandom));
   endtask

   task automatic serve_until_idle();
      while (lcd_mode != MODE_IDLE) begin
         if ($urandom_range(0, 99) < 12)
            send_request(op_type'(2'($urandom_range(OP_WRITE, OP_MOVE))));
         else
            send_tick();
      end
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) send_tick();
   endtask

   task automatic send_string(int len);
      for (int i = 0; i < len; i++) begin
         if (i > 0 && $urandom_range(0, 99) < 5) begin
            send_request($urandom_range(0, 1) ? OP_CLEAR : OP_MOVE);
            serve_until_idle();
         end
         send_item(OP_WRITE, 8'($urandom), (i == len - 1), 2'($urandom), 6'($urandom));
      end
      serve_until_idle();
   endtask

   task automatic settle_bus();
      req_valid <= 1'b0;
      while (pending_pin_states.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_lcd_options(cfg_type opts);
      logic [CSR_INDEX_W-1:0] reg_index [7];
      logic                   reg_value [7];
      reg_index = '{CSR_TWO_LINES, CSR_FONT_LARGE, CSR_DISPLAY_ON, CSR_CURSOR_ON,
                    CSR_BLINK_ON, CSR_INCREMENT_MODE, CSR_DISPLAY_SHIFT};
      reg_value = '{opts.two_lines, opts.font_large, opts.display_on, opts.cursor_on,
                    opts.blink_on, opts.increment_mode, opts.display_shift};
      csr_valid <= 1'b1;
      foreach (reg_index[i]) begin
         csr_index <= reg_index[i];
         csr_wdata <= reg_value[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      lcd_cfg = opts;
   endtask

   // power-on commands, each built from the options in force when E rises
   task automatic test_init_sequence();
      program_lcd_options('1);
      send_item(OP_MOVE, 8'($urandom), 1'($urandom), 2'd1, 6'd63);
      send_tick();
      settle_bus();
      program_lcd_options('0);
      repeat (2) send_tick();
      settle_bus();
      program_lcd_options(cfg_type'(7'($urandom)));
      repeat (3) send_tick();
      settle_bus();
      program_lcd_options(POWER_ON_OPTIONS);
      repeat (4) send_tick();
   endtask

   task automatic test_string_write();
      send_item(OP_WRITE, 8'h00, 1'b0, 2'($urandom), 6'($urandom));
      send_request(OP_CLEAR);
      repeat (2) send_tick();
      send_item(OP_WRITE, 8'hFF, 1'b1, 2'($urandom), 6'($urandom));
      send_item(OP_WRITE, 8'h55, 1'b1, 2'($urandom), 6'($urandom));
      send_request(OP_MOVE);
      repeat (6) send_tick();
   endtask

   task automatic test_cursor_moves();
      send_item(OP_MOVE, 8'($urandom), 1'($urandom), 2'd0, 6'd0);
      repeat (2) send_tick();
      send_item(OP_MOVE, 8'($urandom), 1'($urandom), 2'd3, 6'd21);
      repeat (2) send_tick();
   endtask

   task automatic test_overflow();
      send_string(MAX_STRING_DEF + 2);
      send_string(MAX_STRING_DEF + 1);
   endtask

   task automatic test_random_traffic();
      int phase_start;
      int pick;
      phase_start = handled_items;
      while (handled_items < TOTAL_ITEMS) begin
         if (handled_items - phase_start >= PHASE_ITEMS) begin
            settle_bus();
            program_lcd_options(cfg_type'(7'($urandom)));
            req_quiet   = ($urandom_range(0, 3) == 0);
            rsp_quiet   = ($urandom_range(0, 3) == 0);
            phase_start = handled_items;
         end
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            if ($urandom_range(0, 9) == 0)
               send_string($urandom_range(9, MAX_STRING_DEF + 3));
            else
               send_string($urandom_range(1, 8));
         end else if (pick < 60) begin
            send_request(OP_CLEAR);
            serve_until_idle();
         end else if (pick < 85) begin
            send_request(OP_MOVE);
            serve_until_idle();
         end else begin
            repeat ($urandom_range(1, 4)) send_request(op_type'(2'($urandom)));
            serve_until_idle();
         end
      end
   endtask

   initial begin
      req_valid      <= 1'b0;
      req_kind       <= OP_TICK;
      req_char_code  <= '0;
      req_last_char  <= 1'b0;
      req_row        <= '0;
      req_column     <= '0;
      csr_valid      <= 1'b0;
      csr_index      <= CSR_TWO_LINES;
      csr_wdata      <= 1'b0;
      reset          <= 1'b1;
      handled_items  = 0;
      result_count   = 0;
      mismatch_count = 0;
      req_quiet      = 1'b0;
      rsp_quiet      = 1'b0;
      reset_bus_model();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_init_sequence();
      test_string_write();
      test_cursor_moves();
      test_overflow();
      test_random_traffic();
      settle_bus();
      if (mismatch_count == 0)
         $display("char_lcd_parallel_sequencer regression: pass");
      else
         $display("char_lcd_parallel_sequencer regression: fail");
      $finish;
   end

   // result side back-pressure
   initial begin
      int hold;
      int roll;
      hold = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
         end else if (rsp_quiet) begin
            rsp_stall <= 1'b0;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 65) begin
               rsp_stall <= 1'b0;
            end else if (roll < 95) begin
               rsp_stall <= 1'b1;
               hold = $urandom_range(0, 2);
            end else begin
               rsp_stall <= 1'b1;
               hold = $urandom_range(10, 40);
            end
         end
      end
   end

   always @(posedge clock) begin
      bus_state_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pin_states.size() == 0) begin
            report_mismatch("result with no item pending", {6'b0, rsp_status}, 8'h00);
         end else begin
            want = pending_pin_states.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", {6'b0, rsp_status}, {6'b0, want.status});
            if (rsp_reg_select !== want.rs)
               report_mismatch("reg_select", {7'b0, rsp_reg_select}, {7'b0, want.rs});
            if (rsp_read_write !== want.rw)
               report_mismatch("read_write", {7'b0, rsp_read_write}, {7'b0, want.rw});
            if (rsp_enable_pin !== want.e)
               report_mismatch("enable_pin", {7'b0, rsp_enable_pin}, {7'b0, want.e});
            if (rsp_data_bus !== want.data)
               report_mismatch("data_bus", rsp_data_bus, want.data);
            if (rsp_done_kind !== want.done)
               report_mismatch("done_kind", {6'b0, rsp_done_kind}, {6'b0, want.done});
         end
         result_count++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("char_lcd_parallel_sequencer regression: fail");
            $finish;
         end
      end
   end

endmodule

// File: sim.f
rtl/clps_pkg.sv
rtl/clps_ram.sv
rtl/clps_front.sv
rtl/clps_queue.sv
rtl/clps_back.sv
rtl/char_lcd_parallel_sequencer.sv
tb/char_lcd_parallel_sequencer_tb.sv
